>>> sv/sost_pkg.sv
// ----------------------------------------------------------------------------
// sost_pkg
// Shared constants and types of the seat occupancy session tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sost_pkg;

  localparam int AVG_WINDOW = 8;
  localparam int LOG_DEPTH  = 16;
  localparam int FREE_SCALE = 10;

  localparam int READ_W  = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int FTU_W   = 13;
  localparam int PAUSE_W = FTU_W + 4;
  localparam int SLOT_W  = 4;
  localparam int RING_W  = $clog2(LOG_DEPTH);
  localparam int WIN_W   = $clog2(AVG_WINDOW);
  localparam int SUM_W   = READ_W + $clog2(AVG_WINDOW + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL_A     = 3'd0,
    CFG_EMPTY_LEVEL_B     = 3'd1,
    CFG_HEAVY_MARGIN      = 3'd2,
    CFG_FREE_TIME_UNITS   = 3'd3,
    CFG_SIT_CONFIRM_TICKS = 3'd4,
    CFG_BROKEN_LIMIT_A    = 3'd5,
    CFG_BROKEN_LIMIT_B    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [READ_W-1:0] empty_level_a;
    logic [READ_W-1:0] empty_level_b;
    logic [READ_W-1:0] heavy_margin;
    logic [FTU_W-1:0]  free_time_units;
    logic [COUNT_W-1:0] sit_confirm_ticks;
    logic [READ_W-1:0] broken_limit_a;
    logic [READ_W-1:0] broken_limit_b;
  } cfg_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [READ_W-1:0] reading_a;
    logic [READ_W-1:0] reading_b;
    logic [TIME_W-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic              rider_present;
    logic              sensor_broken;
    logic              session_started;
    logic              session_ended;
    logic [SLOT_W-1:0] log_slot;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
    logic [READ_W-1:0] average_a;
    logic [READ_W-1:0] average_b;
  } out_item_t;

  typedef struct packed {
    logic              rider_present;
    logic              session_started;
    logic              session_ended;
    logic [SLOT_W-1:0] log_slot;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
  } sess_res_t;

endpackage

`default_nettype wire

>>> sv/sost_in_if.sv
// ----------------------------------------------------------------------------
// sost_in_if
// Sample request channel: valid, ready and one tick of readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sost_in_if import sost_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sost_out_if.sv
// ----------------------------------------------------------------------------
// sost_out_if
// Result request channel: valid, ready and one tick of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sost_out_if import sost_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sost_cfg_if.sv
// ----------------------------------------------------------------------------
// sost_cfg_if
// Configuration write channel: valid, ready, register index and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sost_cfg_if import sost_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sost_cfg_regs.sv
// ----------------------------------------------------------------------------
// sost_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sost_cfg_regs import sost_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  sost_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.empty_level_a     <= 16'd1000;
      regs.empty_level_b     <= 16'd1000;
      regs.heavy_margin      <= 16'd100;
      regs.free_time_units   <= 13'd30;
      regs.sit_confirm_ticks <= 16'd50;
      regs.broken_limit_a    <= 16'd60000;
      regs.broken_limit_b    <= 16'd60000;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_EMPTY_LEVEL_A:     regs.empty_level_a     <= cfg.data.value;
        CFG_EMPTY_LEVEL_B:     regs.empty_level_b     <= cfg.data.value;
        CFG_HEAVY_MARGIN:      regs.heavy_margin      <= cfg.data.value;
        CFG_FREE_TIME_UNITS:   regs.free_time_units   <= cfg.data.value[FTU_W-1:0];
        CFG_SIT_CONFIRM_TICKS: regs.sit_confirm_ticks <= cfg.data.value;
        CFG_BROKEN_LIMIT_A:    regs.broken_limit_a    <= cfg.data.value;
        CFG_BROKEN_LIMIT_B:    regs.broken_limit_b    <= cfg.data.value;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/sost_window.sv
// ----------------------------------------------------------------------------
// sost_window
// Moving average over the last AVG_WINDOW readings with a running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sost_window import sost_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               advance,
  input  wire  [READ_W-1:0] sample,
  output logic [READ_W-1:0] average
);

  logic [READ_W-1:0] taps [AVG_WINDOW];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  quot;

  assign sum_next = sum + SUM_W'(sample) - SUM_W'(taps[0]);
  assign quot     = sum_next / SUM_W'(AVG_WINDOW);
  assign average  = quot[READ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < AVG_WINDOW; i++) taps[i] <= '0;
    end else if (advance) begin
      sum <= sum_next;
      for (int i = 0; i < AVG_WINDOW - 1; i++) taps[i] <= taps[i+1];
      taps[AVG_WINDOW-1] <= sample;
    end
  end

endmodule

`default_nettype wire

>>> sv/sost_session.sv
// ----------------------------------------------------------------------------
// sost_session
// Heavy/free counting, session start and end, and the ring slot index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sost_session import sost_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        advance,
  input  in_item_t   item,
  input  cfg_t       regs,
  output sess_res_t  res
);

  logic               rider_flag;
  logic [COUNT_W-1:0] heavy_count;
  logic [COUNT_W-1:0] free_count;
  logic [TIME_W-1:0]  last_heavy_time;
  logic [TIME_W-1:0]  session_start;
  logic [RING_W-1:0]  ring_head;

  logic               rider_flag_next;
  logic [COUNT_W-1:0] heavy_count_next;
  logic [COUNT_W-1:0] free_count_next;
  logic [TIME_W-1:0]  last_heavy_time_next;
  logic [TIME_W-1:0]  session_start_next;
  logic [RING_W-1:0]  ring_head_next;

  logic               heavy;
  logic [COUNT_W-1:0] hc1;
  logic [COUNT_W-1:0] fc1;
  logic [COUNT_W-1:0] hc2;
  logic [PAUSE_W-1:0] pause;
  logic               end_hit;
  logic               start_hit;
  logic               ended;
  logic               started;
  logic               rider2;

  always_comb begin
    heavy = ({1'b0, item.reading_a} + {1'b0, regs.heavy_margin} < {1'b0, regs.empty_level_a})
         || ({1'b0, item.reading_b} + {1'b0, regs.heavy_margin} < {1'b0, regs.empty_level_b});
    hc1 = heavy ? ((heavy_count != COUNT_MAX) ? heavy_count + 1'b1 : heavy_count)
                : heavy_count;
    fc1 = heavy ? '0 : ((free_count != COUNT_MAX) ? free_count + 1'b1 : free_count);
    last_heavy_time_next = heavy ? item.now_seconds : last_heavy_time;

    pause   = PAUSE_W'(regs.free_time_units) * PAUSE_W'(FREE_SCALE);
    end_hit = PAUSE_W'(fc1) > pause;
    ended   = end_hit && rider_flag;
    rider2  = rider_flag && !end_hit;
    hc2     = end_hit ? '0 : hc1;
    free_count_next = end_hit ? '0 : fc1;
    ring_head_next  = !ended ? ring_head
                    : (ring_head == RING_W'(LOG_DEPTH - 1)) ? '0 : ring_head + 1'b1;

    start_hit          = hc2 > regs.sit_confirm_ticks;
    started            = start_hit && !rider2;
    rider_flag_next    = rider2 || start_hit;
    heavy_count_next   = start_hit ? '0 : hc2;
    session_start_next = started ? item.now_seconds : session_start;

    res.rider_present   = rider_flag_next;
    res.session_started = started;
    res.session_ended   = ended;
    res.log_slot        = SLOT_W'(ring_head);
    res.start_time      = session_start_next;
    res.duration        = ended ? last_heavy_time_next - session_start : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rider_flag      <= 1'b0;
      heavy_count     <= '0;
      free_count      <= '0;
      last_heavy_time <= '0;
      session_start   <= '0;
      ring_head       <= '0;
    end else if (advance) begin
      rider_flag      <= rider_flag_next;
      heavy_count     <= heavy_count_next;
      free_count      <= free_count_next;
      last_heavy_time <= last_heavy_time_next;
      session_start   <= session_start_next;
      ring_head       <= ring_head_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/seat_occupancy_session_tracker.sv
// ----------------------------------------------------------------------------
// seat_occupancy_session_tracker
// Seat occupancy session tracker: one result per sensor tick.
//
// Channels: sample_ch takes one request per tick (reading_a, reading_b,
// now_seconds); result_ch returns one request per tick with the session
// flags, ring slot, start time, duration and both moving averages; cfg
// writes one configuration register per request (index 0..6, other
// indexes ignored) and is always ready. Write it only while idle.
// An accepted sample passes through the input register, then the result
// register. Throughput: one tick per cycle while result_ch is ready; the
// session state and the window sums update once per tick, in the cycle
// the tick moves from the input register to the result register.
// Reset (synchronous, active high) restores the register defaults, clears
// the session state and both windows, and empties both registers.
// Receiver stall: the result register holds; if the input register is empty
// it takes one more sample, then sample_ch.ready drops until result_ch moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seat_occupancy_session_tracker import sost_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  sost_in_if.sink     sample_ch,
  sost_out_if.source  result_ch,
  sost_cfg_if.sink    cfg
);

  cfg_t        regs;
  sess_res_t   sess;
  logic        stage_valid;
  in_item_t    stage_item;
  logic        result_valid;
  out_item_t   result_item;
  logic        advance;
  logic [READ_W-1:0] avg_a;
  logic [READ_W-1:0] avg_b;

  assign advance         = stage_valid && (!result_valid || result_ch.ready);
  assign sample_ch.ready = !stage_valid || advance;
  assign result_ch.valid = result_valid;
  assign result_ch.data  = result_item;

  sost_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sost_session u_session (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .regs    (regs),
    .res     (sess)
  );

  sost_window u_win_a (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (stage_item.reading_a),
    .average (avg_a)
  );

  sost_window u_win_b (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (stage_item.reading_b),
    .average (avg_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      stage_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      stage_item <= sample_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item.rider_present   <= sess.rider_present;
      result_item.sensor_broken   <= (avg_a > regs.broken_limit_a)
                                  || (avg_b > regs.broken_limit_b);
      result_item.session_started <= sess.session_started;
      result_item.session_ended   <= sess.session_ended;
      result_item.log_slot        <= sess.log_slot;
      result_item.start_time      <= sess.start_time;
      result_item.duration        <= sess.duration;
      result_item.average_a       <= avg_a;
      result_item.average_b       <= avg_b;
    end
  end

endmodule

`default_nettype wire
